@@ src/tps_pkg.sv @@
// ============================================================================
// tps_pkg
// Shared types, constants and the sine function of the turtle path stepper.
// ============================================================================
package tps_pkg;

    localparam int MAX_STEPS_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int POS_FRAC_BITS   = 8;
    localparam int ANGLE_FRAC_BITS = 7;

    localparam int DIV_W = 24;
    localparam int DVS_W = 16;

    localparam logic [16:0] QUARTER_TURN = 17'(90 << ANGLE_FRAC_BITS);
    localparam logic [16:0] FULL_TURN    = 17'(360 << ANGLE_FRAC_BITS);
    localparam logic [14:0] SIN_ONE      = 15'd16384;
    localparam int          SCALE_SHIFT  = 14;

    localparam logic [1:0] CFG_STEP_LENGTH = 2'd0;
    localparam logic [1:0] CFG_TURN_STEP   = 2'd1;
    localparam logic [1:0] CFG_LIMIT_X     = 2'd2;
    localparam logic [1:0] CFG_LIMIT_Y     = 2'd3;

    typedef enum logic [1:0] {
        OP_FORWARD = 2'd0,
        OP_ROTATE  = 2'd1,
        OP_COLOR   = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVN,
        ST_DIVL,
        ST_WRAP,
        ST_SIN,
        ST_COS,
        ST_MUL,
        ST_RND,
        ST_STEP
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] distance;
        logic [18:0] mag;
        logic        neg;
        logic [23:0] color;
    } cmd_t;

    typedef struct packed {
        logic [10:0] step_length;
        logic [15:0] turn_step;
        logic [10:0] limit_x;
        logic [10:0] limit_y;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

    localparam logic [14:0] SIN_TABLE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    function automatic logic [14:0] quarter_sin(input logic [13:0] a);
        logic [6:0]  d;
        logic [6:0]  f;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [21:0] prod;
        d = a[13:ANGLE_FRAC_BITS];
        f = a[ANGLE_FRAC_BITS-1:0];
        if (d >= 7'd90) begin
            return SIN_ONE;
        end
        lo   = SIN_TABLE[d];
        hi   = SIN_TABLE[d + 7'd1];
        prod = 22'(hi - lo) * 22'(f) + 22'(1 << (ANGLE_FRAC_BITS - 1));
        return lo + 15'(prod >> ANGLE_FRAC_BITS);
    endfunction

    function automatic logic signed [15:0] full_sin(input logic [16:0] a);
        logic [14:0] m;
        logic        neg;
        if (a < QUARTER_TURN) begin
            m   = quarter_sin(a[13:0]);
            neg = 1'b0;
        end else if (a < (QUARTER_TURN << 1)) begin
            m   = quarter_sin(14'((QUARTER_TURN << 1) - a));
            neg = 1'b0;
        end else if (a < (QUARTER_TURN * 3)) begin
            m   = quarter_sin(14'(a - (QUARTER_TURN << 1)));
            neg = 1'b1;
        end else begin
            m   = quarter_sin(14'(FULL_TURN - a));
            neg = 1'b1;
        end
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

@@ src/turtle_path_stepper_top.sv @@
// ============================================================================
// turtle_path_stepper_top
// Turtle-graphics stepper that turns drawing commands into path points.
// ============================================================================
// Commands enter a two-entry queue and are executed one at a time. A forward
// or rotate command runs a division on one shared divider for the step count
// and, if that count is not zero, a second one for the step length or angle
// quotient. It then passes through setup states (WRAP for rotate; SIN, COS,
// MUL and RND for forward) and emits one point per cycle while the output
// register is free, up to MAX_STEPS points. Set colour and clear are executed
// when popped and emit nothing. Configuration writes are always accepted.
module turtle_path_stepper_top #(
    parameter int MAX_STEPS   = tps_pkg::MAX_STEPS_DEF,
    parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [15:0]         distance,
    input  logic signed [18:0]  turn_angle,
    input  logic [23:0]         new_color,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [19:0]  point_x,
    output logic signed [19:0]  point_y,
    output logic [15:0]         point_heading,
    output logic [23:0]         point_color,
    output logic                last_point
);

    tps_pkg::cfg_t     cfg_reg;
    tps_pkg::cmd_t     push_item;
    tps_pkg::cmd_t     pop_item;
    tps_pkg::div_req_t div_req;
    tps_pkg::div_rsp_t div_rsp;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_length <= 11'd1;
            cfg_reg.turn_step   <= 16'd128;
            cfg_reg.limit_x     <= 11'd2047;
            cfg_reg.limit_y     <= 11'd2047;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tps_pkg::CFG_STEP_LENGTH: cfg_reg.step_length <= cfg_data[10:0];
                tps_pkg::CFG_TURN_STEP:   cfg_reg.turn_step   <= cfg_data;
                tps_pkg::CFG_LIMIT_X:     cfg_reg.limit_x     <= cfg_data[10:0];
                default:                  cfg_reg.limit_y     <= cfg_data[10:0];
            endcase
        end
    end

    tps_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .distance   (distance),
        .turn_angle (turn_angle),
        .new_color  (new_color),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    tps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    tps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tps_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_heading (point_heading),
        .point_color   (point_color),
        .last_point    (last_point)
    );

endmodule

@@ src/tps_queue.sv @@
// ============================================================================
// tps_queue
// Small command queue between the front and the back of the stepper.
// ============================================================================
module tps_queue #(
    parameter int DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tps_pkg::cmd_t push_item,
    output logic          full,
    input  logic          pop,
    output tps_pkg::cmd_t pop_item,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tps_pkg::cmd_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/tps_front.sv @@
// ============================================================================
// tps_front
// Input handshake and command classification; pushes decoded items to the queue.
// ============================================================================
module tps_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [15:0]          distance,
    input  logic signed [18:0]   turn_angle,
    input  logic [23:0]          new_color,
    input  logic                 q_full,
    output logic                 q_push,
    output tps_pkg::cmd_t        q_item
);

    tps_pkg::op_t op;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        unique case (operation)
            tps_pkg::OP_FORWARD: op = tps_pkg::OP_FORWARD;
            tps_pkg::OP_ROTATE:  op = tps_pkg::OP_ROTATE;
            tps_pkg::OP_COLOR:   op = tps_pkg::OP_COLOR;
            default:             op = tps_pkg::OP_CLEAR;
        endcase
    end

    always_comb
    begin
        q_item.op       = op;
        q_item.distance = distance;
        q_item.neg      = turn_angle[18];
        q_item.mag      = turn_angle[18] ? 19'(-turn_angle) : 19'(turn_angle);
        q_item.color    = new_color;
    end

endmodule

@@ src/tps_div.sv @@
// ============================================================================
// tps_div
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module tps_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tps_pkg::div_req_t req,
    output tps_pkg::div_rsp_t rsp
);

    localparam int DW = tps_pkg::DIV_W;
    localparam int VW = tps_pkg::DVS_W;
    localparam int NW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= NW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

endmodule

@@ src/tps_back.sv @@
// ============================================================================
// tps_back
// Command execution: step count and length, direction, stepping and output.
// ============================================================================
module tps_back #(
    parameter int MAX_STEPS = tps_pkg::MAX_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tps_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  tps_pkg::cmd_t       q_item,
    output logic                q_pop,
    output tps_pkg::div_req_t   div_req,
    input  tps_pkg::div_rsp_t   div_rsp,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [19:0]  point_x,
    output logic signed [19:0]  point_y,
    output logic [15:0]         point_heading,
    output logic [23:0]         point_color,
    output logic                last_point
);

    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int DW = tps_pkg::DIV_W;
    localparam int VW = tps_pkg::DVS_W;

    tps_pkg::state_t state_reg;
    tps_pkg::state_t state_next;

    tps_pkg::cmd_t         cmd_reg;
    logic signed [19:0]    pos_x_reg;
    logic signed [19:0]    pos_y_reg;
    logic [15:0]           heading_reg;
    logic [23:0]           pen_color_reg;
    logic [NW-1:0]         n_reg;
    logic [NW-1:0]         k_reg;
    logic [NW-1:0]         acc_reg;
    logic [NW-1:0]         rem_reg;
    logic [DW-1:0]         quo_reg;
    logic signed [15:0]    sin_reg;
    logic signed [15:0]    cos_reg;
    logic [39:0]           prod_x_reg;
    logic [39:0]           prod_y_reg;
    logic signed [26:0]    dx_reg;
    logic signed [26:0]    dy_reg;
    logic                  out_valid_reg;
    logic signed [19:0]    out_x_reg;
    logic signed [19:0]    out_y_reg;
    logic [15:0]           out_heading_reg;
    logic [23:0]           out_color_reg;
    logic                  out_last_reg;

    logic                  is_move;
    logic                  emit;
    logic                  last;
    logic [NW-1:0]         n_sat;
    logic [10:0]           sl_eff;
    logic [15:0]           ts_eff;
    logic [16:0]           cos_arg;
    logic [15:0]           sin_abs;
    logic [15:0]           cos_abs;
    logic [25:0]           rnd_x;
    logic [25:0]           rnd_y;
    logic signed [26:0]    lim_x;
    logic signed [26:0]    lim_y;
    logic signed [26:0]    sum_x;
    logic signed [26:0]    sum_y;
    logic signed [19:0]    new_x;
    logic signed [19:0]    new_y;
    logic [NW:0]           acc_sum;
    logic                  carry;
    logic [NW-1:0]         acc_new;
    logic [16:0]           inc;
    logic [16:0]           h_up;
    logic signed [17:0]    h_dn;
    logic [15:0]           new_heading;

    assign is_move = (q_item.op == tps_pkg::OP_FORWARD) || (q_item.op == tps_pkg::OP_ROTATE);
    assign sl_eff  = (cfg.step_length == '0) ? 11'd1 : cfg.step_length;
    assign ts_eff  = (cfg.turn_step == '0) ? 16'd1 : cfg.turn_step;
    assign n_sat   = (div_rsp.quotient > DW'(MAX_STEPS)) ? NW'(MAX_STEPS)
                                                         : div_rsp.quotient[NW-1:0];
    assign emit    = (state_reg == tps_pkg::ST_STEP) && (!out_valid_reg || out_ready);
    assign last    = ((k_reg + 1'b1) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tps_pkg::ST_IDLE:
            begin
                if (!q_empty && is_move)
                begin
                    state_next = tps_pkg::ST_DIVN;
                end
            end
            tps_pkg::ST_DIVN:
            begin
                if (div_rsp.done)
                begin
                    state_next = (n_sat == '0) ? tps_pkg::ST_IDLE : tps_pkg::ST_DIVL;
                end
            end
            tps_pkg::ST_DIVL:
            begin
                if (div_rsp.done)
                begin
                    state_next = (cmd_reg.op == tps_pkg::OP_FORWARD) ? tps_pkg::ST_SIN
                                                                     : tps_pkg::ST_WRAP;
                end
            end
            tps_pkg::ST_WRAP:
            begin
                if (quo_reg < DW'(tps_pkg::FULL_TURN))
                begin
                    state_next = tps_pkg::ST_STEP;
                end
            end
            tps_pkg::ST_SIN:  state_next = tps_pkg::ST_COS;
            tps_pkg::ST_COS:  state_next = tps_pkg::ST_MUL;
            tps_pkg::ST_MUL:  state_next = tps_pkg::ST_RND;
            tps_pkg::ST_RND:  state_next = tps_pkg::ST_STEP;
            tps_pkg::ST_STEP:
            begin
                if (emit && last)
                begin
                    state_next = tps_pkg::ST_IDLE;
                end
            end
            default: state_next = tps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            tps_pkg::ST_IDLE:
            begin
                q_pop         = !q_empty;
                div_req.start = !q_empty && is_move;
                if (q_item.op == tps_pkg::OP_FORWARD)
                begin
                    div_req.dividend = DW'(q_item.distance);
                    div_req.divisor  = VW'(sl_eff);
                end
                else
                begin
                    div_req.dividend = DW'(q_item.mag);
                    div_req.divisor  = ts_eff;
                end
            end
            tps_pkg::ST_DIVN:
            begin
                div_req.start   = div_rsp.done && (n_sat != '0);
                div_req.divisor = VW'(n_sat);
                if (cmd_reg.op == tps_pkg::OP_FORWARD)
                begin
                    div_req.dividend = DW'(cmd_reg.distance) << tps_pkg::POS_FRAC_BITS;
                end
                else
                begin
                    div_req.dividend = DW'(cmd_reg.mag);
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cos_arg = 17'(heading_reg) + tps_pkg::QUARTER_TURN;
        if (cos_arg >= tps_pkg::FULL_TURN)
        begin
            cos_arg = cos_arg - tps_pkg::FULL_TURN;
        end
        sin_abs = sin_reg[15] ? 16'(-sin_reg) : 16'(sin_reg);
        cos_abs = cos_reg[15] ? 16'(-cos_reg) : 16'(cos_reg);
        rnd_x   = 26'((prod_x_reg + 40'(1 << (tps_pkg::SCALE_SHIFT - 1)))
                      >> tps_pkg::SCALE_SHIFT);
        rnd_y   = 26'((prod_y_reg + 40'(1 << (tps_pkg::SCALE_SHIFT - 1)))
                      >> tps_pkg::SCALE_SHIFT);

        lim_x = $signed(27'(cfg.limit_x) << tps_pkg::POS_FRAC_BITS);
        lim_y = $signed(27'(cfg.limit_y) << tps_pkg::POS_FRAC_BITS);
        sum_x = 27'(pos_x_reg) + dx_reg;
        sum_y = 27'(pos_y_reg) + dy_reg;
        if (sum_x > lim_x)
        begin
            new_x = 20'(lim_x);
        end
        else if (sum_x < -lim_x)
        begin
            new_x = 20'(-lim_x);
        end
        else
        begin
            new_x = 20'(sum_x);
        end
        if (sum_y > lim_y)
        begin
            new_y = 20'(lim_y);
        end
        else if (sum_y < -lim_y)
        begin
            new_y = 20'(-lim_y);
        end
        else
        begin
            new_y = 20'(sum_y);
        end

        acc_sum = {1'b0, acc_reg} + {1'b0, rem_reg};
        carry   = (acc_sum >= {1'b0, n_reg});
        acc_new = carry ? NW'(acc_sum - {1'b0, n_reg}) : acc_sum[NW-1:0];
        inc     = 17'(quo_reg[15:0]) + 17'(carry);
        h_up    = 17'(heading_reg) + inc;
        h_dn    = $signed({2'b00, heading_reg}) - $signed({1'b0, inc});
        if (cmd_reg.neg)
        begin
            new_heading = (h_dn < 0) ? 16'(h_dn + $signed({1'b0, tps_pkg::FULL_TURN}))
                                     : 16'(h_dn);
        end
        else
        begin
            new_heading = (h_up >= tps_pkg::FULL_TURN) ? 16'(h_up - tps_pkg::FULL_TURN)
                                                       : 16'(h_up);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tps_pkg::ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            pen_color_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop && (q_item.op == tps_pkg::OP_COLOR))
            begin
                pen_color_reg <= q_item.color;
            end
            if (q_pop && (q_item.op == tps_pkg::OP_CLEAR))
            begin
                pos_x_reg     <= '0;
                pos_y_reg     <= '0;
                heading_reg   <= '0;
                pen_color_reg <= '0;
            end
            if (emit)
            begin
                if (cmd_reg.op == tps_pkg::OP_FORWARD)
                begin
                    pos_x_reg <= new_x;
                    pos_y_reg <= new_y;
                end
                else
                begin
                    heading_reg <= new_heading;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_item;
        end
        if ((state_reg == tps_pkg::ST_DIVN) && div_rsp.done)
        begin
            n_reg   <= n_sat;
            k_reg   <= '0;
            acc_reg <= '0;
        end
        if ((state_reg == tps_pkg::ST_DIVL) && div_rsp.done)
        begin
            quo_reg <= div_rsp.quotient;
            rem_reg <= div_rsp.remainder[NW-1:0];
        end
        if ((state_reg == tps_pkg::ST_WRAP) && (quo_reg >= DW'(tps_pkg::FULL_TURN)))
        begin
            quo_reg <= quo_reg - DW'(tps_pkg::FULL_TURN);
        end
        if (state_reg == tps_pkg::ST_SIN)
        begin
            sin_reg <= tps_pkg::full_sin(17'(heading_reg));
        end
        if (state_reg == tps_pkg::ST_COS)
        begin
            cos_reg <= tps_pkg::full_sin(cos_arg);
        end
        if (state_reg == tps_pkg::ST_MUL)
        begin
            prod_x_reg <= 40'(quo_reg) * 40'(sin_abs);
            prod_y_reg <= 40'(quo_reg) * 40'(cos_abs);
        end
        if (state_reg == tps_pkg::ST_RND)
        begin
            dx_reg <= sin_reg[15] ? $signed({1'b0, rnd_x}) : -$signed({1'b0, rnd_x});
            dy_reg <= cos_reg[15] ? -$signed({1'b0, rnd_y}) : $signed({1'b0, rnd_y});
        end
        if (emit)
        begin
            k_reg           <= k_reg + 1'b1;
            acc_reg         <= acc_new;
            out_last_reg    <= last;
            out_color_reg   <= pen_color_reg;
            if (cmd_reg.op == tps_pkg::OP_FORWARD)
            begin
                out_x_reg       <= new_x;
                out_y_reg       <= new_y;
                out_heading_reg <= heading_reg;
            end
            else
            begin
                out_x_reg       <= pos_x_reg;
                out_y_reg       <= pos_y_reg;
                out_heading_reg <= new_heading;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = out_x_reg;
    assign point_y       = out_y_reg;
    assign point_heading = out_heading_reg;
    assign point_color   = out_color_reg;
    assign last_point    = out_last_reg;

endmodule
